// ===== design/rv32c_pkg.sv =====
// Package with shared types and constants for the RV32C compressed execute block.
package rv32c_pkg;
    localparam int NUM_REGS = 32;
    localparam int REG_AW = 5;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ILLEGAL = 2'd1,
        ST_BREAK   = 2'd2,
        ST_ORDER   = 2'd3
    } t_status;

    localparam logic CMD_EXEC = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        mem_read;
        logic        mem_write;
        logic [31:0] mem_addr;
        logic [31:0] mem_wdata;
        logic        reg_write;
        logic [4:0]  reg_index;
        logic [31:0] reg_value;
        t_status     status;
    } t_result;

    typedef struct packed {
        logic        cmd;
        logic [15:0] instr;
        logic [31:0] load_data;
    } t_item;
endpackage

// ===== design/rv32c_if.sv =====
// Valid/ready channel interfaces for input items and result items.
interface rv32c_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [15:0] instr;
    logic [31:0] load_data;
    modport source (output valid, cmd, instr, load_data, input ready);
    modport sink (input valid, cmd, instr, load_data, output ready);
endinterface

interface rv32c_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] next_pc;
    logic        mem_read;
    logic        mem_write;
    logic [31:0] mem_addr;
    logic [31:0] mem_wdata;
    logic        reg_write;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic [1:0]  status;
    modport source (output valid, next_pc, mem_read, mem_write, mem_addr, mem_wdata,
                    reg_write, reg_index, reg_value, status, input ready);
    modport sink (input valid, next_pc, mem_read, mem_write, mem_addr, mem_wdata,
                  reg_write, reg_index, reg_value, status, output ready);
endinterface

// ===== design/rv32c_exec.sv =====
// Combinational decode and execute of one compressed instruction or load return.
module rv32c_exec (
    input  rv32c_pkg::t_item   i_item,
    input  logic [31:0]        i_pc,
    input  logic               i_load_pending,
    input  logic [4:0]         i_load_dest,
    input  logic [31:0]        i_ra,
    input  logic [31:0]        i_rb,
    input  logic [31:0]        i_sp,
    output logic [4:0]         o_ra_idx,
    output logic [4:0]         o_rb_idx,
    output rv32c_pkg::t_result o_res,
    output logic               o_load_set,
    output logic               o_load_clr,
    output logic [4:0]         o_load_dest
);
    logic [15:0] c;
    logic [2:0]  f;
    logic [4:0]  r5, s5, rp, sp3;
    logic [31:0] imm6, cj, cb, u, wval, addr, wdata, npc, a, b;
    logic [5:0]  sh;
    logic        ill, wr, mr, mw, brk;
    logic [4:0]  widx;
    logic        r5ok, s5ok;

    assign c    = i_item.instr;
    assign f    = c[15:13];
    assign r5   = c[11:7];
    assign s5   = c[6:2];
    assign rp   = {2'b01, c[9:7]};
    assign sp3  = {2'b01, c[4:2]};
    assign sh   = {c[12], c[6:2]};
    assign imm6 = {{26{c[12]}}, c[12], c[6:2]};
    assign cj   = {{21{c[12]}}, c[8], c[10:9], c[6], c[7], c[2], c[11], c[5:3], 1'b0};
    assign cb   = {{24{c[12]}}, c[6:5], c[2], c[11:10], c[4:3], 1'b0};
    assign r5ok = 32'(r5) < rv32c_pkg::NUM_REGS;
    assign s5ok = 32'(s5) < rv32c_pkg::NUM_REGS;
    assign a    = i_ra;
    assign b    = i_rb;

    always_comb begin
        o_ra_idx = r5;
        o_rb_idx = s5;
        case (c[1:0])
            2'd0: begin
                o_ra_idx = rp;
                o_rb_idx = sp3;
            end
            2'd1: begin
                o_ra_idx = rp;
                o_rb_idx = sp3;
                if (f == 3'd0 || f == 3'd2 || f == 3'd3) o_ra_idx = r5;
            end
            default: ;
        endcase
    end

    always_comb begin
        ill = 1'b0; wr = 1'b0; mr = 1'b0; mw = 1'b0; brk = 1'b0;
        widx = '0; wval = '0; addr = '0; wdata = '0; u = '0;
        npc = i_pc + 32'd2;
        case (c[1:0])
            2'd0: begin
                if (f == 3'd0) begin
                    u = {22'd0, c[10:7], c[12:11], c[5], c[6], 2'b00};
                    if (u == 32'd0) ill = 1'b1;
                    else begin
                        wr = 1'b1; widx = sp3; wval = i_sp + u;
                    end
                end else if (f == 3'd2 || f == 3'd6) begin
                    u = {25'd0, c[5], c[12:10], c[6], 2'b00};
                    addr = a + u;
                    if (f == 3'd2) mr = 1'b1;
                    else begin
                        mw = 1'b1; wdata = b;
                    end
                end else ill = 1'b1;
            end
            2'd1: begin
                case (f)
                    3'd0: if (!r5ok) ill = 1'b1;
                          else begin wr = 1'b1; widx = r5; wval = a + imm6; end
                    3'd1: begin
                        wr = 1'b1; widx = 5'd1; wval = i_pc + 32'd2; npc = i_pc + cj;
                    end
                    3'd2: if (!r5ok) ill = 1'b1;
                          else begin wr = 1'b1; widx = r5; wval = imm6; end
                    3'd3: begin
                        if (r5 == 5'd2) begin
                            u = {{23{c[12]}}, c[4:3], c[5], c[2], c[6], 4'd0};
                            if ({c[12], c[6:2]} == 6'd0) ill = 1'b1;
                            else begin wr = 1'b1; widx = 5'd2; wval = i_sp + u; end
                        end else begin
                            u = {{14{c[12]}}, c[12], c[6:2], 12'd0};
                            if ({c[12], c[6:2]} == 6'd0 || !r5ok) ill = 1'b1;
                            else begin wr = 1'b1; widx = r5; wval = u; end
                        end
                    end
                    3'd4: begin
                        wr = 1'b1; widx = rp;
                        case (c[11:10])
                            2'd0: if (sh[5]) ill = 1'b1; else wval = a >> sh[4:0];
                            2'd1: if (sh[5]) ill = 1'b1;
                                  else wval = 32'($signed(a) >>> sh[4:0]);
                            2'd2: wval = a & imm6;
                            default: begin
                                if (c[12]) ill = 1'b1;
                                else case (c[6:5])
                                    2'd0: wval = a - b;
                                    2'd1: wval = a ^ b;
                                    2'd2: wval = a | b;
                                    default: wval = a & b;
                                endcase
                            end
                        endcase
                    end
                    3'd5: npc = i_pc + cj;
                    3'd6: if (a == 32'd0) npc = i_pc + cb;
                    default: if (a != 32'd0) npc = i_pc + cb;
                endcase
            end
            2'd2: begin
                case (f)
                    3'd0: if (sh[5] || !r5ok) ill = 1'b1;
                          else begin wr = 1'b1; widx = r5; wval = a << sh[4:0]; end
                    3'd2: begin
                        u = {24'd0, c[3:2], c[12], c[6:4], 2'b00};
                        if (r5 == 5'd0 || !r5ok) ill = 1'b1;
                        else begin mr = 1'b1; addr = i_sp + u; end
                    end
                    3'd4: begin
                        if (!r5ok || !s5ok) ill = 1'b1;
                        else if (!c[12]) begin
                            if (s5 == 5'd0) begin
                                if (r5 == 5'd0) ill = 1'b1; else npc = a;
                            end else begin
                                wr = 1'b1; widx = r5; wval = b;
                            end
                        end else if (s5 == 5'd0) begin
                            if (r5 == 5'd0) brk = 1'b1;
                            else begin
                                wr = 1'b1; widx = 5'd1; wval = i_pc + 32'd2; npc = a;
                            end
                        end else begin
                            wr = 1'b1; widx = r5; wval = a + b;
                        end
                    end
                    3'd6: begin
                        u = {24'd0, c[8:7], c[12:9], 2'b00};
                        if (!s5ok) ill = 1'b1;
                        else begin mw = 1'b1; addr = i_sp + u; wdata = b; end
                    end
                    default: ill = 1'b1;
                endcase
            end
            default: ill = 1'b1;
        endcase
    end

    always_comb begin
        o_res = '0;
        o_res.next_pc = i_pc;
        o_res.status = rv32c_pkg::ST_OK;
        o_load_set = 1'b0;
        o_load_clr = 1'b0;
        o_load_dest = (c[1:0] == 2'd0) ? sp3 : r5;
        if (i_item.cmd == rv32c_pkg::CMD_LOAD || i_load_pending) begin
            if (i_item.cmd == rv32c_pkg::CMD_LOAD && i_load_pending) begin
                o_load_clr = 1'b1;
                if (i_load_dest != 5'd0) begin
                    o_res.reg_write = 1'b1;
                    o_res.reg_index = i_load_dest;
                    o_res.reg_value = i_item.load_data;
                end
            end else o_res.status = rv32c_pkg::ST_ORDER;
        end else if (ill) begin
            o_res.status = rv32c_pkg::ST_ILLEGAL;
        end else begin
            o_res.next_pc = npc;
            o_res.mem_read = mr;
            o_res.mem_write = mw;
            o_res.mem_addr = (mr || mw) ? addr : 32'd0;
            o_res.mem_wdata = mw ? wdata : 32'd0;
            if (wr && widx != 5'd0) begin
                o_res.reg_write = 1'b1;
                o_res.reg_index = widx;
                o_res.reg_value = wval;
            end
            o_load_set = mr;
            o_res.status = brk ? rv32c_pkg::ST_BREAK : rv32c_pkg::ST_OK;
        end
    end
endmodule

// ===== design/rv32c_compressed_execute_top.sv =====
// Top level of the RV32C compressed execute block.
// One transaction is taken per cycle; its result appears in the output register
// the next cycle. Register file reads, decode and write-back happen in the cycle the
// transaction is accepted, so a following instruction sees the update at once.
// Input ready follows output ready or an empty output register. A configuration write
// (i_cfg_we) loads the program counter from i_cfg_wdata, over any accepted transaction's update.
module rv32c_compressed_execute_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [31:0]        i_cfg_wdata,
    rv32c_in_if.sink           i_in,
    rv32c_out_if.source        o_out
);
    logic [31:0]        r_regs [rv32c_pkg::NUM_REGS];
    logic [31:0]        r_pc;
    logic               r_load_pending;
    logic [4:0]         r_load_dest;
    logic               r_valid;
    rv32c_pkg::t_result r_res;
    rv32c_pkg::t_result n_res;
    rv32c_pkg::t_item   item;
    logic [4:0]         ra_idx, rb_idx, ld_dest;
    logic [31:0]        ra, rb, spv;
    logic               ld_set, ld_clr, acc;

    function automatic logic [31:0] rd(input logic [31:0] regs [rv32c_pkg::NUM_REGS],
                                       input logic [4:0] idx);
        logic [31:0] v;
        v = '0;
        for (int k = 1; k < rv32c_pkg::NUM_REGS; k++)
            if (32'(idx) == k) v = regs[k];
        return v;
    endfunction

    assign item = '{cmd: i_in.cmd, instr: i_in.instr, load_data: i_in.load_data};
    assign ra = rd(r_regs, ra_idx);
    assign rb = rd(r_regs, rb_idx);
    assign spv = rd(r_regs, 5'd2);
    assign i_in.ready = !r_valid || o_out.ready;
    assign acc = i_in.valid && i_in.ready;

    rv32c_exec u_exec (
        .i_item(item), .i_pc(r_pc), .i_load_pending(r_load_pending),
        .i_load_dest(r_load_dest), .i_ra(ra), .i_rb(rb), .i_sp(spv),
        .o_ra_idx(ra_idx), .o_rb_idx(rb_idx), .o_res(n_res),
        .o_load_set(ld_set), .o_load_clr(ld_clr), .o_load_dest(ld_dest)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pc <= '0;
            r_load_pending <= 1'b0;
            r_load_dest <= '0;
            for (int k = 0; k < rv32c_pkg::NUM_REGS; k++) r_regs[k] <= '0;
        end else begin
            if (acc) begin
                r_valid <= 1'b1;
                r_res <= n_res;
                r_pc <= n_res.next_pc;
                if (n_res.reg_write) r_regs[n_res.reg_index] <= n_res.reg_value;
                if (ld_set) begin
                    r_load_pending <= 1'b1;
                    r_load_dest <= ld_dest;
                end else if (ld_clr) r_load_pending <= 1'b0;
            end else if (o_out.ready) r_valid <= 1'b0;
            if (i_cfg_we) r_pc <= i_cfg_wdata;
        end
    end

    assign o_out.valid = r_valid;
    assign o_out.next_pc = r_res.next_pc;
    assign o_out.mem_read = r_res.mem_read;
    assign o_out.mem_write = r_res.mem_write;
    assign o_out.mem_addr = r_res.mem_addr;
    assign o_out.mem_wdata = r_res.mem_wdata;
    assign o_out.reg_write = r_res.reg_write;
    assign o_out.reg_index = r_res.reg_index;
    assign o_out.reg_value = r_res.reg_value;
    assign o_out.status = r_res.status;
endmodule
